FILE: sv/urbft_pkg.sv
// Shared types and constants for the serial-port ring buffer with frame timeout.
// No dependencies.
package urbft_pkg;

  typedef enum logic [2:0] {
    ACT_PUT  = 3'd0,
    ACT_DONE = 3'd1,
    ACT_RX   = 3'd2,
    ACT_TICK = 3'd3,
    ACT_READ = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUT_DATA,
    ST_TX_READ,
    ST_TX_WAIT,
    ST_RX_MOD,
    ST_RX_WAIT
  } state_t;

  // register index on the config bus (paddr[2])
  localparam logic REG_RX_IDLE_TICKS = 1'b0;
  localparam logic REG_CRLF_EXPAND   = 1'b1;

  localparam logic [7:0] RX_IDLE_TICKS_RST = 8'd10;
  localparam logic       CRLF_EXPAND_RST   = 1'b1;

  localparam logic [7:0] LF_BYTE = 8'h0A;
  localparam logic [7:0] CR_BYTE = 8'h0D;

endpackage

FILE: sv/uart_ring_buffer_with_frame_timeout_unit.sv
// Top level: transmit ring, receive store and idle-tick frame timeout.
// Depends on urbft_pkg.
//
// channel   handshake                 payload
// -------   ----------------------    ---------------------------------------------
// in        start & !busy             in_action, in_data_byte, in_read_index
// out       out_valid (1-cycle pulse) out_send_valid, out_send_byte, out_sending,
//                                     out_frame_done, out_frame_length, out_read_byte
// config    psel & penable & pwrite   paddr, pwdata, prdata, pready (always 1)
//
// An accepted item goes to ST_DECODE, which gives the result beat for an rx byte, a
// tick, a done that sends nothing, a put while the sender runs and an unknown action.
// A read goes on via ST_RX_MOD and ST_RX_WAIT; a done that sends and a put that starts
// the sender via ST_TX_READ and ST_TX_WAIT; an LF put that writes a CR via ST_PUT_DATA
// first. The next item can be accepted at the edge that ends the beat. Reset is
// synchronous and clears pointers, flags and counters; the stores are not cleared.
module uart_ring_buffer_with_frame_timeout_unit
  import urbft_pkg::*;
#(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_read_index,

  output logic        out_valid,
  output logic        out_send_valid,
  output logic [7:0]  out_send_byte,
  output logic        out_sending,
  output logic        out_frame_done,
  output logic [7:0]  out_frame_length,
  output logic [7:0]  out_read_byte,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(BUFFER_DEPTH - 1);
  localparam logic [8:0]    DEPTH_9  = 9'(BUFFER_DEPTH);

  logic [7:0] tx_mem [BUFFER_DEPTH];
  logic [7:0] rx_mem [BUFFER_DEPTH];

  state_t        state_r, state_nxt;
  logic [2:0]    act_r, act_nxt;
  logic [7:0]    data_r, data_nxt;
  logic [7:0]    idx_r, idx_nxt;
  logic [AW-1:0] tx_wp_r, tx_wp_nxt;
  logic [AW-1:0] tx_rp_r, tx_rp_nxt;
  logic          tx_running_r, tx_running_nxt;
  logic [AW-1:0] rx_count_r, rx_count_nxt;
  logic [7:0]    rx_timer_r, rx_timer_nxt;
  logic [7:0]    last_len_r, last_len_nxt;
  logic [7:0]    idle_ticks_r, idle_ticks_nxt;
  logic          crlf_r, crlf_nxt;

  logic          valid_r, valid_nxt;
  logic          send_valid_r, send_valid_nxt;
  logic [7:0]    send_byte_r, send_byte_nxt;
  logic          frame_done_r, frame_done_nxt;
  logic [7:0]    read_byte_r, read_byte_nxt;

  logic          tx_we, tx_re, rx_we, rx_re;
  logic [AW-1:0] tx_waddr, rx_addr;
  logic [7:0]    tx_wdata;
  logic [7:0]    tx_rdata_r, rx_rdata_r;

  logic          cfg_wr;

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    return (p == LAST_POS) ? '0 : p + 1'b1;
  endfunction

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CRLF_EXPAND) ? {31'd0, crlf_r} : {24'd0, idle_ticks_r};

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    data_nxt       = data_r;
    idx_nxt        = idx_r;
    tx_wp_nxt      = tx_wp_r;
    tx_rp_nxt      = tx_rp_r;
    tx_running_nxt = tx_running_r;
    rx_count_nxt   = rx_count_r;
    rx_timer_nxt   = rx_timer_r;
    last_len_nxt   = last_len_r;
    idle_ticks_nxt = idle_ticks_r;
    crlf_nxt       = crlf_r;
    valid_nxt      = 1'b0;
    send_valid_nxt = send_valid_r;
    send_byte_nxt  = send_byte_r;
    frame_done_nxt = frame_done_r;
    read_byte_nxt  = read_byte_r;
    tx_we          = 1'b0;
    tx_re          = 1'b0;
    rx_we          = 1'b0;
    rx_re          = 1'b0;
    tx_waddr       = tx_wp_r;
    tx_wdata       = data_r;
    rx_addr        = rx_count_r;

    if (cfg_wr) begin
      unique case (paddr[2])
        REG_RX_IDLE_TICKS: idle_ticks_nxt = pwdata[7:0];
        REG_CRLF_EXPAND:   crlf_nxt       = pwdata[0];
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt        = in_action;
          data_nxt       = in_data_byte;
          idx_nxt        = in_read_index;
          send_valid_nxt = 1'b0;
          send_byte_nxt  = '0;
          frame_done_nxt = 1'b0;
          read_byte_nxt  = '0;
          state_nxt      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (act_r)
          ACT_PUT: begin
            tx_we     = 1'b1;
            tx_wp_nxt = next_pos(tx_wp_r);
            if (crlf_r && data_r == LF_BYTE) begin
              tx_wdata  = CR_BYTE;
              state_nxt = ST_PUT_DATA;
            end else if (!tx_running_r) begin
              state_nxt = ST_TX_READ;
            end else begin
              valid_nxt = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          ACT_DONE: begin
            if (tx_running_r && tx_rp_r != tx_wp_r) begin
              state_nxt = ST_TX_READ;
            end else begin
              tx_running_nxt = 1'b0;
              valid_nxt      = 1'b1;
              state_nxt      = ST_IDLE;
            end
          end
          ACT_RX: begin
            rx_we        = 1'b1;
            rx_count_nxt = next_pos(rx_count_r);
            rx_timer_nxt = idle_ticks_r;
            valid_nxt    = 1'b1;
            state_nxt    = ST_IDLE;
          end
          ACT_TICK: begin
            if (rx_count_r != '0) begin
              if (rx_timer_r == '0) begin
                last_len_nxt   = 8'(rx_count_r);
                rx_count_nxt   = '0;
                frame_done_nxt = 1'b1;
              end
              rx_timer_nxt = rx_timer_r - 1'b1;
            end
            valid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end
          ACT_READ: state_nxt = ST_RX_MOD;
          default: begin
            valid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_PUT_DATA: begin
        tx_we     = 1'b1;
        tx_wp_nxt = next_pos(tx_wp_r);
        if (!tx_running_r) begin
          state_nxt = ST_TX_READ;
        end else begin
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_TX_READ: begin
        // issued in the cycle after the last write so a fresh byte is seen
        tx_re     = 1'b1;
        state_nxt = ST_TX_WAIT;
      end
      ST_TX_WAIT: begin
        send_valid_nxt = 1'b1;
        send_byte_nxt  = tx_rdata_r;
        tx_rp_nxt      = next_pos(tx_rp_r);
        tx_running_nxt = 1'b1;
        valid_nxt      = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_RX_MOD: begin
        // fold read_index below the depth, one subtract per cycle
        if ({1'b0, idx_r} >= DEPTH_9) begin
          idx_nxt = idx_r - 8'(BUFFER_DEPTH);
        end else begin
          rx_re     = 1'b1;
          rx_addr   = idx_r[AW-1:0];
          state_nxt = ST_RX_WAIT;
        end
      end
      ST_RX_WAIT: begin
        read_byte_nxt = rx_rdata_r;
        valid_nxt     = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tx_we) tx_mem[tx_waddr] <= tx_wdata;
    if (tx_re) tx_rdata_r <= tx_mem[tx_rp_r];
    if (rx_we) rx_mem[rx_addr] <= data_r;
    if (rx_re) rx_rdata_r <= rx_mem[rx_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tx_wp_r      <= '0;
      tx_rp_r      <= '0;
      tx_running_r <= 1'b0;
      rx_count_r   <= '0;
      rx_timer_r   <= '0;
      last_len_r   <= '0;
      idle_ticks_r <= RX_IDLE_TICKS_RST;
      crlf_r       <= CRLF_EXPAND_RST;
      valid_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tx_wp_r      <= tx_wp_nxt;
      tx_rp_r      <= tx_rp_nxt;
      tx_running_r <= tx_running_nxt;
      rx_count_r   <= rx_count_nxt;
      rx_timer_r   <= rx_timer_nxt;
      last_len_r   <= last_len_nxt;
      idle_ticks_r <= idle_ticks_nxt;
      crlf_r       <= crlf_nxt;
      valid_r      <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    data_r       <= data_nxt;
    idx_r        <= idx_nxt;
    send_valid_r <= send_valid_nxt;
    send_byte_r  <= send_byte_nxt;
    frame_done_r <= frame_done_nxt;
    read_byte_r  <= read_byte_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = valid_r;
  assign out_send_valid   = send_valid_r;
  assign out_send_byte    = send_byte_r;
  assign out_sending      = tx_running_r;
  assign out_frame_done   = frame_done_r;
  assign out_frame_length = last_len_r;
  assign out_read_byte    = read_byte_r;

endmodule

FILE: tb/uart_buffer_checker.sv
// Scoreboard for the serial-port ring buffer: watches the item, result and register
// ports, keeps its own copy of the buffer state and checks every result beat.
// Depends on urbft_pkg.
module uart_buffer_checker
  import urbft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_read_index,
  input  logic        out_valid,
  input  logic        out_send_valid,
  input  logic [7:0]  out_send_byte,
  input  logic        out_sending,
  input  logic        out_frame_done,
  input  logic [7:0]  out_frame_length,
  input  logic [7:0]  out_read_byte,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       sending;
    logic       frame_done;
    logic [7:0] frame_length;
    logic [7:0] read_byte;
  } reply_t;

  // shadow of the buffer; 8-bit pointers wrap like the 256-deep rings
  logic [7:0] tx_ring [256];
  logic [7:0] rx_frame_mem [256];
  logic [7:0] tx_wr, tx_rd, rx_fill, idle_left, frame_len_q;
  logic       tx_on;
  logic [7:0] idle_limit = RX_IDLE_TICKS_RST;
  logic       add_cr = CRLF_EXPAND_RST;

  reply_t awaited_replies [$];
  int     fails = 0;

  assign mismatches = fails;

  task automatic log_failure(input string msg);
    $display("%0t ns: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      log_failure($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  function automatic reply_t step_buffers(input logic [2:0] act, input logic [7:0] data,
                                          input logic [7:0] idx);
    reply_t r;
    r = '0;
    case (act)
      ACT_PUT: begin
        if (add_cr && data == LF_BYTE) begin
          tx_ring[tx_wr] = CR_BYTE;
          tx_wr = tx_wr + 8'd1;
        end
        tx_ring[tx_wr] = data;
        tx_wr = tx_wr + 8'd1;
        if (!tx_on) begin
          tx_on = 1'b1;
          r.send_valid = 1'b1;
          r.send_byte = tx_ring[tx_rd];
          tx_rd = tx_rd + 8'd1;
        end
      end
      ACT_DONE: begin
        if (tx_on) begin
          if (tx_rd == tx_wr) begin
            tx_on = 1'b0;
          end else begin
            r.send_valid = 1'b1;
            r.send_byte = tx_ring[tx_rd];
            tx_rd = tx_rd + 8'd1;
          end
        end
      end
      ACT_RX: begin
        idle_left = idle_limit;
        rx_frame_mem[rx_fill] = data;
        rx_fill = rx_fill + 8'd1;
      end
      ACT_TICK: begin
        // a wrapped count of zero means no frame is open
        if (rx_fill != 8'd0) begin
          if (idle_left == 8'd0) begin
            frame_len_q = rx_fill;
            rx_fill = 8'd0;
            r.frame_done = 1'b1;
          end
          idle_left = idle_left - 8'd1;
        end
      end
      ACT_READ: r.read_byte = rx_frame_mem[idx];
      default: ;
    endcase
    r.sending = tx_on;
    r.frame_length = frame_len_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst_n) begin
      tx_wr = '0;
      tx_rd = '0;
      tx_on = 1'b0;
      rx_fill = '0;
      idle_left = '0;
      frame_len_q = '0;
      idle_limit = RX_IDLE_TICKS_RST;
      add_cr = CRLF_EXPAND_RST;
      awaited_replies.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_RX_IDLE_TICKS: idle_limit = pwdata[7:0];
          REG_CRLF_EXPAND:   add_cr = pwdata[0];
        endcase
      end
      if (out_valid) begin
        if (awaited_replies.size() == 0) begin
          log_failure("result beat with no item pending");
        end else begin
          want = awaited_replies.pop_front();
          check_field("send_valid", {7'd0, out_send_valid}, {7'd0, want.send_valid});
          check_field("send_byte", out_send_byte, want.send_byte);
          check_field("sending", {7'd0, out_sending}, {7'd0, want.sending});
          check_field("frame_done", {7'd0, out_frame_done}, {7'd0, want.frame_done});
          check_field("frame_length", out_frame_length, want.frame_length);
          check_field("read_byte", out_read_byte, want.read_byte);
        end
      end
      if (start && !busy)
        awaited_replies.push_back(step_buffers(in_action, in_data_byte, in_read_index));
    end
    outstanding <= awaited_replies.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the serial-port ring buffer testbench: clock, reset, item and register
// stimulus, and the verdict. Depends on urbft_pkg, the unit and uart_buffer_checker.
module testbench;
  import urbft_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_action;
  logic [7:0]  in_data_byte;
  logic [7:0]  in_read_index;
  logic        out_valid;
  logic        out_send_valid;
  logic [7:0]  out_send_byte;
  logic        out_sending;
  logic        out_frame_done;
  logic [7:0]  out_frame_length;
  logic [7:0]  out_read_byte;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          outstanding;

  int          items_sent = 0;
  bit          no_gaps = 1'b0;
  logic [7:0]  idle_cfg = RX_IDLE_TICKS_RST;

  uart_ring_buffer_with_frame_timeout_unit dut (.*);
  uart_buffer_checker u_check (.*);

  always #4 clk = ~clk;

  // one item beat; start stays high when the next item follows without a gap
  task automatic issue(input logic [2:0] act, input logic [7:0] data, input logic [7:0] idx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_data_byte <= data;
    in_read_index <= idx;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic drain(input int extra);
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] ticks, input logic expand);
    drain(4);
    write_reg(REG_RX_IDLE_TICKS, {24'd0, ticks});
    write_reg(REG_CRLF_EXPAND, {31'd0, expand});
    idle_cfg = ticks;
  endtask

  function automatic logic [7:0] tx_byte();
    return ($urandom_range(0, 3) == 0) ? LF_BYTE : 8'($urandom_range(0, 255));
  endfunction

  task automatic random_traffic(input int budget);
    int stop_at, n, kind, tails;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // puts with some dones mixed in; an occasional flood wraps the ring
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 6);
        repeat (n) begin
          issue(ACT_PUT, tx_byte(), 8'($urandom_range(0, 255)));
          if ($urandom_range(0, 2) == 0)
            issue(ACT_DONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(n, 2 * n + 1))
          issue(ACT_DONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (kind < 8) begin
        // frame: bytes, sometimes a few ticks between them, then the idle run
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        repeat (n) begin
          issue(ACT_RX, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(0, (idle_cfg < 4) ? idle_cfg : 4))
              issue(ACT_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        tails = idle_cfg + $urandom_range(0, 3);
        repeat (tails)
          issue(ACT_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0)
          issue(ACT_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 4))
          issue(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6))
          issue(ACT_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_action <= ACT_TICK;
    in_data_byte <= '0;
    in_read_index <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset settings
    issue(ACT_TICK, 8'h00, 8'h00);    // no frame open
    issue(ACT_DONE, 8'h00, 8'h00);    // sender idle
    issue(ACT_PUT, 8'h00, 8'h00);
    issue(ACT_PUT, 8'hFF, 8'hFF);
    issue(ACT_PUT, LF_BYTE, 8'h00);   // CR goes in first
    repeat (4) issue(ACT_DONE, 8'h00, 8'h00);
    issue(ACT_RX, 8'h00, 8'h00);
    issue(ACT_RX, 8'hFF, 8'h00);
    issue(ACT_READ, 8'h00, 8'h00);
    issue(ACT_READ, 8'h00, 8'h01);
    repeat (12) issue(ACT_TICK, 8'h00, 8'h00);
    issue(3'd5, 8'hA5, 8'h5A);
    issue(3'd7, 8'hFF, 8'hFF);

    // full-depth frame: count wraps to zero so ticks do nothing; fills every entry
    repeat (256) issue(ACT_RX, 8'($urandom_range(0, 255)), 8'h00);
    repeat (2) issue(ACT_TICK, 8'h00, 8'h00);
    issue(ACT_READ, 8'h00, 8'h00);
    issue(ACT_READ, 8'h00, 8'hFF);

    random_traffic(80);
    set_config(8'd0, 1'b0);
    random_traffic(80);
    set_config(8'd255, 1'b1);
    random_traffic(120);
    set_config(8'd1, 1'b1);
    random_traffic(60);
    set_config(8'($urandom_range(2, 20)), 1'($urandom_range(0, 1)));
    random_traffic(60);

    drain(10);
    if (mismatches == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
